// ===== rtl/queue_with_middle_removal_unit_defines.svh =====
// Assertion macros shared by the queue with middle removal RTL.
`ifndef QUEUE_WITH_MIDDLE_REMOVAL_UNIT_DEFINES_SVH
`define QUEUE_WITH_MIDDLE_REMOVAL_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check a property at every rising clock edge outside reset.
`define QWMR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent in one cycle implies a consequent in the next.
`define QWMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QWMR_ASSERT(lbl, clk, rst_n, prop, msg)
`define QWMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/qwmr_pkg.sv =====
// Types and constants of the queue with middle removal.
package qwmr_pkg;

  localparam int unsigned DefaultMaxDepth = 1024;
  localparam int unsigned CapW            = 11;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned CodeW           = 2;
  localparam logic [CapW-1:0] CapacityReset = CapW'(1024);

  // Request codes; the unused code acts as a middle removal.
  localparam logic [CodeW-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [CodeW-1:0] REQ_FRONT   = 2'd1;
  localparam logic [CodeW-1:0] REQ_MIDDLE  = 2'd2;

  // Result status codes.
  localparam logic [CodeW-1:0] STATUS_OK    = 2'd0;
  localparam logic [CodeW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [CodeW-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [CodeW-1:0]         req_type;
    logic signed [ValueW-1:0] value;
  } qwmr_req_t;

  typedef struct packed {
    logic [CodeW-1:0]         status;
    logic signed [ValueW-1:0] removed_value;
  } qwmr_res_t;

endpackage

// ===== rtl/qwmr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module qwmr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/queue_with_middle_removal_unit.sv =====
// Top level of the bounded queue with front and middle removal.
//
// Usage: a request (req_i) is taken at a rising edge with start high and busy
// low. Enqueue appends req_i.value unless the queue holds the capacity or
// MAX_DEPTH; front removal returns the oldest entry; middle removal returns
// entry ceil(k/2) of k. Each request is read and then written back: the accept
// edge reads both half stores, the next edge writes them back and updates the
// pointers, so busy is high for one cycle after every accept. This read then
// write-back means a new request is taken only once the last is written back.
// A result (res_o) is shown for exactly one cycle with strobe_o high, in the
// cycle right after the busy cycle; the receiver cannot stall it, and a new
// request may be accepted in that same cycle. A successful enqueue gives no
// result; a full queue or an empty removal gives a status with a zero value.
// The user must write the capacity register (cfg_we_i / cfg_wdata_i) only while
// idle; the block does not enforce it. Reset empties the queue, sets capacity to
// 1024 and needs no clearing pass: only entries holding queued values are used.
module queue_with_middle_removal_unit
  import qwmr_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DefaultMaxDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  qwmr_req_t       req_i,
  output logic            strobe_o,
  output qwmr_res_t       res_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

`include "queue_with_middle_removal_unit_defines.svh"

  localparam int unsigned HalfDepth = (MAX_DEPTH + 1) / 2;
  localparam int unsigned AW  = (HalfDepth > 1) ? $clog2(HalfDepth) : 1;
  localparam int unsigned CW  = $clog2(HalfDepth + 1);
  localparam int unsigned TW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned SW  = ((AW > CW) ? AW : CW) + 1;
  localparam int unsigned LW  = (TW > CapW) ? TW : CapW;
  localparam logic [LW-1:0] MaxDepthL = LW'(MAX_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_e;

  // Ring position head + off, wrapped once at the half depth.
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(off);
    if (sum >= SW'(HalfDepth)) begin
      sum = sum - SW'(HalfDepth);
    end
    return sum[AW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic            strobe_q, strobe_d;
  qwmr_res_t       res_q, res_d;
  qwmr_req_t       req_q;
  logic [CapW-1:0] capacity_q;
  logic [AW-1:0]   fhead_q, fhead_d, bhead_q, bhead_d;
  logic [CW-1:0]   fcount_q, fcount_d, bcount_q, bcount_d;

  logic            accept;
  logic [AW-1:0]   front_raddr;
  logic [ValueW-1:0] front_rdata, back_rdata;
  logic            front_we, back_we;
  logic [AW-1:0]   front_waddr, back_waddr;
  logic [ValueW-1:0] front_wdata;

  logic            is_enq, is_front, is_full, is_empty, balanced;
  logic            enq_ok, rem_ok, move;
  logic [LW-1:0]   total;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_WORK);

  // Front half read address: head for a front removal or when empty, else tail.
  always_comb begin
    if (req_i.req_type == REQ_FRONT || fcount_q == '0) begin
      front_raddr = fhead_q;
    end else begin
      front_raddr = ring_pos(fhead_q, fcount_q - CW'(1));
    end
  end

  qwmr_ram #(
    .WIDTH(ValueW),
    .DEPTH(HalfDepth)
  ) u_front_ram (
    .clk_i  (clk_i),
    .we_i   (front_we),
    .waddr_i(front_waddr),
    .wdata_i(front_wdata),
    .re_i   (accept),
    .raddr_i(front_raddr),
    .rdata_o(front_rdata)
  );

  // The back half is always read at its head: the candidate for rebalancing.
  qwmr_ram #(
    .WIDTH(ValueW),
    .DEPTH(HalfDepth)
  ) u_back_ram (
    .clk_i  (clk_i),
    .we_i   (back_we),
    .waddr_i(back_waddr),
    .wdata_i(req_q.value),
    .re_i   (accept),
    .raddr_i(bhead_q),
    .rdata_o(back_rdata)
  );

  // Decode the held request and its outcome in the work cycle.
  always_comb begin
    is_enq   = 1'b0;
    is_front = 1'b0;
    unique case (req_q.req_type)
      REQ_ENQUEUE: is_enq = 1'b1;
      REQ_FRONT:   is_front = 1'b1;
      default:     ;
    endcase
    total    = LW'(fcount_q) + LW'(bcount_q);
    is_full  = (total >= LW'(capacity_q)) || (total >= MaxDepthL);
    is_empty = (fcount_q == '0);
    balanced = (fcount_q == bcount_q);
    enq_ok   = busy && is_enq && !is_full;
    rem_ok   = busy && !is_enq && !is_empty;
    // The halves differ by at most one, so one move restores the balance.
    move     = (enq_ok || rem_ok) && balanced;
  end

  // Write back: enqueue into the back tail, move the back head to the front tail.
  always_comb begin
    back_we    = enq_ok && !is_empty;
    back_waddr = ring_pos(bhead_q, bcount_q);
    front_we   = move;
    if (rem_ok && !is_front) begin
      front_waddr = ring_pos(fhead_q, fcount_q - CW'(1));
    end else begin
      front_waddr = ring_pos(fhead_q, fcount_q);
    end
    // Both halves empty: forward the new value straight to the front half.
    front_wdata = (is_enq && is_empty) ? req_q.value : back_rdata;
  end

  // Pointer and count update.
  always_comb begin
    fhead_d  = fhead_q;
    fcount_d = fcount_q;
    bhead_d  = bhead_q;
    bcount_d = bcount_q;
    if (rem_ok && is_front) begin
      fhead_d = ring_pos(fhead_q, CW'(1));
    end
    if (move) begin
      bhead_d = ring_pos(bhead_q, CW'(1));
    end
    if (enq_ok) begin
      if (move) begin
        fcount_d = fcount_q + CW'(1);
      end else begin
        bcount_d = bcount_q + CW'(1);
      end
    end
    if (rem_ok) begin
      if (move) begin
        bcount_d = bcount_q - CW'(1);
      end else begin
        fcount_d = fcount_q - CW'(1);
      end
    end
  end

  // Sequencer and result register.
  always_comb begin
    state_d  = state_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        state_d = ST_IDLE;
        if (is_enq) begin
          if (is_full) begin
            strobe_d = 1'b1;
            res_d    = '{status: STATUS_FULL, removed_value: '0};
          end
        end else if (is_empty) begin
          strobe_d = 1'b1;
          res_d    = '{status: STATUS_EMPTY, removed_value: '0};
        end else begin
          strobe_d = 1'b1;
          res_d    = '{status: STATUS_OK, removed_value: front_rdata};
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fhead_q    <= '0;
      fcount_q   <= '0;
      bhead_q    <= '0;
      bcount_q   <= '0;
      capacity_q <= CapacityReset;
    end else begin
      fhead_q  <= fhead_d;
      fcount_q <= fcount_d;
      bhead_q  <= bhead_d;
      bcount_q <= bcount_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the request for the work cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  // Front half holds ceil(k/2): equal to the back half or one more.
  `QWMR_ASSERT(a_halves_balanced, clk_i, rst_ni, (fcount_q == bcount_q) || (fcount_q == bcount_q + CW'(1)), "halves out of balance")
  `QWMR_ASSERT(a_total_bounded, clk_i, rst_ni, (LW'(fcount_q) + LW'(bcount_q)) <= MaxDepthL, "queue holds more than its depth")
  `QWMR_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy && !strobe_o, "accepted request not in work")
  `QWMR_ASSERT(a_strobe_idle, clk_i, rst_ni, !(strobe_o && busy), "result shown while busy")

endmodule

// ===== test/queue_with_middle_removal_unit_tb.sv =====
// Self-checking testbench for the queue with front and middle removal.
module queue_with_middle_removal_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qwmr_pkg::*;

  // The fourth request code has no name in the package; the block treats it
  // as a middle removal.
  localparam logic [CodeW-1:0] REQ_SPARE = 2'd3;

  localparam int unsigned HalfDepth    = (DefaultMaxDepth + 1) / 2;
  // Cycles after the last accept before the block counts as idle. This covers
  // the busy cycle, the result cycle and some margin.
  localparam int          SettleCycles = 6;
  localparam int          CycleLimit   = 200000;

  typedef enum logic [1:0] {
    STEP_REQ,   // one request for the block
    STEP_CFG,   // capacity write, issued once the block is idle
    STEP_HOLD   // pause until every expected result has arrived
  } step_kind_e;

  typedef struct {
    step_kind_e      kind;
    qwmr_req_t       req;
    logic [CapW-1:0] cap;
  } step_t;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  qwmr_req_t       req       = '0;
  logic            strobe;
  qwmr_res_t       res;
  logic            cfg_we    = 1'b0;
  logic [CapW-1:0] cfg_wdata = '0;

  queue_with_middle_removal_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .strobe_o   (strobe),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Work still to be sent, and the results the shadow queue says must come.
  step_t     step_q[$];
  qwmr_res_t outcome_q[$];

  // Shadow copy of the queue: two ring halves, with the front half holding
  // the oldest ceil(k/2) entries.
  logic signed [ValueW-1:0] front_mem [HalfDepth];
  logic signed [ValueW-1:0] back_mem  [HalfDepth];
  int unsigned     front_head = 0;
  int unsigned     front_cnt  = 0;
  int unsigned     back_head  = 0;
  int unsigned     back_cnt   = 0;
  logic [CapW-1:0] cap_model  = CapacityReset;

  int   cycle_count  = 0;
  int   quiet_cycles = 0;
  int   mismatches   = 0;
  logic req_taken    = 1'b0;
  int   burst_left   = 8;
  int   gap_left     = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Move the oldest back-half entry to the tail of the front half whenever
  // the front half has fallen behind.
  task automatic settle_halves();
    if (front_cnt < back_cnt) begin
      front_mem[(front_head + front_cnt) % HalfDepth] = back_mem[back_head];
      back_head = (back_head + 1) % HalfDepth;
      back_cnt--;
      front_cnt++;
    end
  endtask

  // Apply one accepted request to the shadow queue and queue up the result
  // it must give, if any.
  task automatic mirror_apply(input qwmr_req_t r);
    int unsigned lim;
    int unsigned pos;
    qwmr_res_t   out;
    lim = (cap_model < DefaultMaxDepth) ? int'(cap_model) : DefaultMaxDepth;
    out.status        = STATUS_OK;
    out.removed_value = '0;
    if (r.req_type == REQ_ENQUEUE) begin
      if (front_cnt + back_cnt >= lim) begin
        // Full: report it and leave the queue alone.
        out.status = STATUS_FULL;
        outcome_q = {outcome_q, out};
      end else begin
        // A successful append gives no result.
        back_mem[(back_head + back_cnt) % HalfDepth] = r.value;
        back_cnt++;
        settle_halves();
      end
    end else if (front_cnt == 0) begin
      out.status = STATUS_EMPTY;
      outcome_q = {outcome_q, out};
    end else begin
      // Front removal takes the head of the front half; middle removal (and
      // the spare code) takes its tail.
      if (r.req_type == REQ_FRONT) begin
        pos        = front_head;
        front_head = (front_head + 1) % HalfDepth;
      end else begin
        pos = (front_head + front_cnt - 1) % HalfDepth;
      end
      out.removed_value = front_mem[pos];
      front_cnt--;
      settle_halves();
      outcome_q = {outcome_q, out};
    end
  endtask

  function automatic void push_request(logic [CodeW-1:0] code, logic [ValueW-1:0] v);
    step_t s;
    s.kind         = STEP_REQ;
    s.req.req_type = code;
    s.req.value    = v;
    s.cap          = '0;
    step_q = {step_q, s};
  endfunction

  function automatic void push_setting(logic [CapW-1:0] c);
    step_t s;
    s.kind = STEP_CFG;
    s.req  = '0;
    s.cap  = c;
    step_q = {step_q, s};
  endfunction

  function automatic void push_hold();
    step_t s;
    s.kind = STEP_HOLD;
    s.req  = '0;
    s.cap  = '0;
    step_q = {step_q, s};
  endfunction

  // Half appends, the rest split among the three removal codes.
  function automatic logic [CodeW-1:0] pick_code();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return REQ_ENQUEUE;
    if (roll < 7) return REQ_FRONT;
    if (roll < 9) return REQ_MIDDLE;
    return REQ_SPARE;
  endfunction

  // Sample at the rising edge: check results first, then record an accepted
  // request, so a result never meets the expectation of a newer request.
  always @(posedge clk_i) begin : sample_proc
    qwmr_res_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (strobe) begin
        if (outcome_q.size() == 0) begin
          $error("result with nothing expected: status %0d value %0d",
                 res.status, res.removed_value);
          mismatches++;
        end else begin
          want = outcome_q[0];
          outcome_q.delete(0);
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            mismatches++;
          end
          if (res.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   want.removed_value, res.removed_value);
            mismatches++;
          end
        end
      end
      if (cfg_we) cap_model = cfg_wdata;
      if (start && !busy) begin
        mirror_apply(req);
        req_taken    = 1'b1;
        quiet_cycles = 0;
      end else if (quiet_cycles < 1000) begin
        quiet_cycles++;
      end
    end
  end

  // Drive at the falling edge. Every input gets one assignment per edge,
  // worked out in locals first, so start stays high across back-to-back
  // requests without dropping.
  always @(negedge clk_i) begin : drive_proc
    step_t           head;
    logic            nxt_start;
    logic            nxt_we;
    qwmr_req_t       nxt_req;
    logic [CapW-1:0] nxt_wdata;
    nxt_start = 1'b0;
    nxt_we    = 1'b0;
    nxt_req   = req;
    nxt_wdata = cfg_wdata;
    if (rst_ni) begin
      if (start && !req_taken) begin
        // Hold the request until the block takes it.
        nxt_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (step_q.size() != 0) begin
        head = step_q[0];
        if (head.kind == STEP_REQ) begin
          step_q.delete(0);
          nxt_start = 1'b1;
          nxt_req   = head.req;
          // Send in bursts; after each burst idle for a while. Some bursts
          // are long so there are stretches without any idling.
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 15)
                                                     : $urandom_range(1, 4);
          end
        end else if (outcome_q.size() == 0 && quiet_cycles >= SettleCycles) begin
          // Block is idle: safe to drop a pause or write the capacity.
          step_q.delete(0);
          if (head.kind == STEP_CFG) begin
            nxt_we    = 1'b1;
            nxt_wdata = head.cap;
          end
        end
      end
    end
    req_taken = 1'b0;
    start     <= nxt_start;
    req       <= nxt_req;
    cfg_we    <= nxt_we;
    cfg_wdata <= nxt_wdata;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // Directed part, at the reset capacity: removals on an empty queue with
    // every removal code.
    push_request(REQ_FRONT, 32'h1234_5678);
    push_request(REQ_MIDDLE, 32'hFFFF_FFFF);
    push_request(REQ_SPARE, 32'h0);
    // Extreme and alternating values, then drain with mixed removals so the
    // middle is taken at odd and even fill levels.
    push_request(REQ_ENQUEUE, 32'h8000_0000);
    push_request(REQ_ENQUEUE, 32'h7FFF_FFFF);
    push_request(REQ_ENQUEUE, 32'h0000_0000);
    push_request(REQ_ENQUEUE, 32'hFFFF_FFFF);
    push_request(REQ_ENQUEUE, 32'h5555_5555);
    push_request(REQ_ENQUEUE, 32'hAAAA_AAAA);
    push_request(REQ_MIDDLE, 32'h0);
    push_request(REQ_FRONT, 32'h0);
    push_request(REQ_SPARE, 32'h0);
    push_request(REQ_MIDDLE, 32'h0);
    push_request(REQ_FRONT, 32'h0);
    push_request(REQ_MIDDLE, 32'h0);
    push_request(REQ_MIDDLE, 32'h0);
    // Zero capacity: every append reports full.
    push_setting('0);
    push_request(REQ_ENQUEUE, 32'h0000_0001);
    push_request(REQ_FRONT, 32'h0);
    // Capacity one: second append is full, middle of one entry is the entry.
    push_setting(CapW'(1));
    push_request(REQ_ENQUEUE, 32'h0000_0005);
    push_request(REQ_ENQUEUE, 32'h0000_0006);
    push_request(REQ_MIDDLE, 32'h0);

    // Random part with small capacities: the queue keeps hitting full and
    // empty.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: push_setting(CapW'(2));
        1: push_setting(CapW'(3));
        2: push_setting(CapW'($urandom_range(4, 16)));
        3: push_setting(CapW'(1));
        4: push_setting(CapW'($urandom_range(17, 48)));
        default: push_setting(CapW'($urandom_range(2, 9)));
      endcase
      for (int i = 0; i < 55; i++) begin
        push_request(pick_code(), $urandom());
        if ($urandom_range(0, 24) == 0) push_hold();
      end
    end

    // Largest capacity, above the depth: fill past the depth so both halves
    // run full and the full status is hit at the store limit.
    push_setting('1);
    for (int i = 0; i < 1140; i++) begin
      if ($urandom_range(0, 99) < 96) push_request(REQ_ENQUEUE, $urandom());
      else push_request(($urandom_range(0, 1) == 0) ? REQ_FRONT : REQ_MIDDLE, $urandom());
      if (i == 600) push_hold();
    end
    for (int i = 0; i < 30; i++) push_request(pick_code() | 2'b01, $urandom());
    // Back to the reset capacity with the queue still well filled.
    push_setting(CapacityReset);
    for (int i = 0; i < 12; i++) push_request(pick_code(), $urandom());

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all stimulus to go out, then for every result, then let the
    // block settle so a stray strobe would still be caught.
    while (step_q.size() != 0 || start || cfg_we) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles * 2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
